/* design/csld_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package csld_pkg;

    localparam int ANGLE_W  = 27;
    localparam int CHANGE_W = 28;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_POINT   = 8'h2E;
    localparam logic [7:0] CHAR_LOWER_O = 8'h6F;
    localparam logic [7:0] CHAR_LOWER_U = 8'h75;
    localparam logic [7:0] CHAR_LOWER_T = 8'h74;
    localparam logic [7:0] CHAR_LOWER_I = 8'h69;
    localparam logic [7:0] CHAR_LOWER_N = 8'h6E;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 27'd134217727;

    localparam logic signed [CHANGE_W-1:0] HALF_TURN = 28'sd180000;
    localparam logic signed [CHANGE_W-1:0] FULL_TURN = 28'sd360000;

    typedef enum logic [1:0] {
        EV_ANGLE    = 2'd0,
        EV_DOCKED   = 2'd1,
        EV_UNDOCKED = 2'd2
    } t_event_kind;

    typedef struct packed {
        logic                       valid;
        t_event_kind                kind;
        logic signed [CHANGE_W-1:0] change;
    } t_result;

endpackage

`default_nettype wire

/* design/csld_line.sv */
`timescale 1ns / 1ps
`default_nettype none

// Line collector with a running angle parse. Each stored character advances
// the millidegree value by one step, so a newline only needs the wrap logic.
module csld_line
    import csld_pkg::*;
#(
    parameter int LINE_CHARS = 5
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic [7:0] i_rx_byte,
    output t_result         o_result
);

    localparam int LEN_W = $clog2(LINE_CHARS + 1);

    typedef enum logic [2:0] {
        PH_WHOLE = 3'b001,
        PH_FRAC  = 3'b010,
        PH_DONE  = 3'b100
    } t_phase;

    logic [7:0]         r_head [3];
    logic [7:0]         n_head [3];
    logic [LEN_W-1:0]   r_len, n_len;
    logic [ANGLE_W-1:0] r_milli, n_milli;
    logic [1:0]         r_fcnt, n_fcnt;
    t_phase             r_phase, n_phase;
    logic [ANGLE_W-1:0] r_prev, n_prev;
    logic               r_prev_valid, n_prev_valid;

    logic                       is_newline;
    logic                       store;
    logic                       is_digit;
    logic [3:0]                 digit;
    logic [31:0]                whole_sum;
    logic [31:0]                frac_sum;
    logic [9:0]                 frac_scale;
    logic                       angle_line;
    logic signed [CHANGE_W-1:0] diff;
    logic signed [CHANGE_W-1:0] wrapped;

    assign is_newline = (i_rx_byte == CHAR_NEWLINE);
    assign store      = i_load && !is_newline && (r_len < LEN_W'(LINE_CHARS));
    assign is_digit   = (i_rx_byte >= CHAR_ZERO) && (i_rx_byte <= CHAR_NINE);
    assign digit      = 4'(i_rx_byte - CHAR_ZERO);

    // whole part: value * 10 + digit * 1000, clamped
    assign whole_sum = {2'd0, r_milli, 3'd0} + {4'd0, r_milli, 1'b0}
                     + 32'(digit) * 32'd1000;

    always_comb begin
        case (r_fcnt)
            2'd0:    frac_scale = 10'd100;
            2'd1:    frac_scale = 10'd10;
            default: frac_scale = 10'd1;
        endcase
    end

    assign frac_sum = 32'(r_milli) + 32'(digit) * 32'(frac_scale);

    always_comb begin
        n_milli = r_milli;
        n_fcnt  = r_fcnt;
        n_phase = r_phase;
        if (store) begin
            unique case (r_phase)
                PH_WHOLE: begin
                    if (is_digit) begin
                        n_milli = (whole_sum > 32'(ANGLE_MAX)) ? ANGLE_MAX
                                                               : whole_sum[ANGLE_W-1:0];
                    end else if (i_rx_byte == CHAR_POINT) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_FRAC: begin
                    if (is_digit) begin
                        if (r_fcnt != 2'd3) begin
                            n_milli = (frac_sum > 32'(ANGLE_MAX)) ? ANGLE_MAX
                                                                  : frac_sum[ANGLE_W-1:0];
                            n_fcnt  = r_fcnt + 2'd1;
                        end
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end else if (i_load && is_newline) begin
            n_milli = '0;
            n_fcnt  = '0;
            n_phase = PH_WHOLE;
        end
    end

    always_comb begin
        n_len = r_len;
        for (int k = 0; k < 3; k++) begin
            n_head[k] = r_head[k];
        end
        if (store) begin
            n_len = r_len + LEN_W'(1);
            for (int k = 0; k < 3; k++) begin
                if (r_len == LEN_W'(k)) begin
                    n_head[k] = i_rx_byte;
                end
            end
        end else if (i_load && is_newline) begin
            n_len = '0;
            for (int k = 0; k < 3; k++) begin
                n_head[k] = '0;
            end
        end
    end

    // angle line: cleared store means a zero head byte, never a digit
    assign angle_line = (r_head[0] >= CHAR_ZERO) && (r_head[0] <= CHAR_NINE);

    assign diff = $signed({1'b0, r_milli}) - $signed({1'b0, r_prev});

    always_comb begin
        if (diff > HALF_TURN) begin
            wrapped = diff - FULL_TURN;
        end else if (diff < -HALF_TURN) begin
            wrapped = diff + FULL_TURN;
        end else begin
            wrapped = diff;
        end
    end

    always_comb begin
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        o_result     = '{valid: 1'b0, kind: EV_ANGLE, change: '0};
        if (i_load && is_newline) begin
            if (angle_line) begin
                n_prev       = r_milli;
                n_prev_valid = 1'b1;
                o_result     = '{valid: r_prev_valid && (wrapped != '0),
                                 kind: EV_ANGLE, change: wrapped};
            end else if (r_len == LEN_W'(4) && r_head[0] == CHAR_LOWER_O
                         && r_head[1] == CHAR_LOWER_U && r_head[2] == CHAR_LOWER_T) begin
                o_result = '{valid: 1'b1, kind: EV_DOCKED, change: '0};
            end else if (r_len == LEN_W'(3) && r_head[0] == CHAR_LOWER_I
                         && r_head[1] == CHAR_LOWER_N) begin
                o_result = '{valid: 1'b1, kind: EV_UNDOCKED, change: '0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_head[k] <= '0;
            end
            r_len        <= '0;
            r_milli      <= '0;
            r_fcnt       <= '0;
            r_phase      <= PH_WHOLE;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
        end else begin
            for (int k = 0; k < 3; k++) begin
                r_head[k] <= n_head[k];
            end
            r_len        <= n_len;
            r_milli      <= n_milli;
            r_fcnt       <= n_fcnt;
            r_phase      <= n_phase;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
        end
    end

endmodule

`default_nettype wire

/* design/crank_serial_line_decoder_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Crank serial line decoder.
// Input channel (i_valid / o_stall / i_rx_byte): one received serial byte per
// transfer. Bytes up to a newline form a line of at most LINE_CHARS characters;
// extra characters are dropped.
// Output channel (o_valid / i_stall / o_event_kind / o_angle_change): at most
// one event per newline: an angle change in millidegrees (wrapped to +-180
// degrees, zero changes suppressed), crank docked, or crank undocked.
// Throughput: one byte per cycle while o_stall is low. The angle is
// accumulated as each character arrives, so a newline needs only one
// subtract and wrap before the result register. The event is registered into
// the result register, or the skid buffer while that register is still full.
// The result register is backed by a one-entry skid buffer: input keeps
// flowing while a result waits; o_stall rises only once both entries hold
// results, and drops when the receiver takes one.
// Reset (synchronous, active low) clears the line, the stored angle and its
// valid flag, and empties the output buffer.
module crank_serial_line_decoder_core
    import csld_pkg::*;
#(
    parameter int LINE_CHARS = 5
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [7:0]                 i_rx_byte,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [1:0]                      o_event_kind,
    output logic signed [CHANGE_W-1:0]      o_angle_change
);

    logic    load;
    logic    take;
    t_result line_result;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign o_stall = r_skid_valid;
    assign load    = i_valid && !r_skid_valid;
    assign take    = r_out_valid && !i_stall;

    csld_line #(
        .LINE_CHARS (LINE_CHARS)
    ) u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_rx_byte (i_rx_byte),
        .o_result  (line_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (line_result.valid) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (load && line_result.valid) begin
            if (r_out_valid && !take) begin
                r_skid <= line_result;
            end else begin
                r_out <= line_result;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_event_kind   = r_out.kind;
    assign o_angle_change = r_out.change;

endmodule

`default_nettype wire
